// ===== src/fbpa_pkg.sv =====
// Package for the fixed block pool allocator: word types, codes, reset values
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 16;
    localparam int BCNT_W         = 7;
    localparam int USED_W         = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int SCAN_W         = 8;
    localparam int MAX_BLOCKS_DEF = 64;

    localparam logic [ADDR_W-1:0] BASE_ADDR_RST   = 32'd4096;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;
    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type         req_type;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] block_address;
        logic [USED_W-1:0] used_count;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_GRANT,
        S_BOUND,
        S_CHECK,
        S_DIV,
        S_RELEASE,
        S_CLEAR,
        S_NOP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    mul_idx;
        logic    mul_cnt;
        logic    grant;
        logic    div_start;
        logic    release_blk;
        logic    clear;
        logic    finish;
        t_status status;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_hit;
        logic scan_last;
        logic addr_bad;
        logic div_done;
        logic slot_used;
    } t_dp_stat;

endpackage

// ===== src/fbpa_div.sv =====
// Restoring divider for the free path: 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle. Depends on fbpa_pkg for the widths.
`timescale 1ns / 1ps

module fbpa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fbpa_pkg::ADDR_W-1:0] i_dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [fbpa_pkg::ADDR_W-1:0] o_quotient
);
    import fbpa_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);

    logic [SIZE_W:0]     r_rem, n_rem;
    logic [ADDR_W-1:0]   r_quo, n_quo;
    logic [SIZE_W-1:0]   r_dvs;
    logic [STEP_W-1:0]   r_step;
    logic                r_run;
    logic                r_done;
    logic [SIZE_W:0]     trial;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
        trial = {r_rem[SIZE_W-1:0], r_quo[ADDR_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = trial - {1'b0, r_dvs};
            n_quo = {r_quo[ADDR_W-2:0], 1'b1};
        end else begin
            n_rem = trial;
            n_quo = {r_quo[ADDR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ADDR_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/fbpa_ctrl.sv =====
// Controller state machine of the block pool allocator: sequences allocate,
// free and clear requests through the datapath. Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fbpa_pkg::t_req_type i_req_type,
    input  fbpa_pkg::t_dp_stat  i_stat,
    output logic                o_busy,
    output fbpa_pkg::t_cmd      o_cmd
);
    import fbpa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        o_busy       = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        REQ_ALLOC: n_state = S_SCAN;
                        REQ_FREE:  n_state = S_BOUND;
                        REQ_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_NOP;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_MUL;
                end else if (i_stat.scan_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_EXHAUSTED;
                    n_state      = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul_idx = 1'b1;
                n_state       = S_GRANT;
            end
            S_GRANT: begin
                o_cmd.grant  = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_BOUND: begin
                o_cmd.mul_cnt = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.addr_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_INVALID;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_RELEASE;
                end
            end
            S_RELEASE: begin
                o_cmd.finish = 1'b1;
                if (i_stat.slot_used) begin
                    o_cmd.release_blk = 1'b1;
                end else begin
                    o_cmd.status = ST_NOT_ALLOC;
                end
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clear  = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_NOP: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fbpa_dpath.sv =====
// Datapath of the block pool allocator: configuration registers, in-use map,
// used count, free-block scan, multiplier, bound check and result register.
// Depends on fbpa_pkg and instantiates fbpa_div.
`timescale 1ns / 1ps

module fbpa_dpath #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  fbpa_pkg::t_req                  i_req,
    input  fbpa_pkg::t_cmd                  i_cmd,
    output fbpa_pkg::t_dp_stat              o_stat,
    output fbpa_pkg::t_result               o_result,
    output logic                            o_result_valid
);
    import fbpa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NCHUNK = (MAX_BLOCKS + SCAN_W - 1) / SCAN_W;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SEL_W  = $clog2(SCAN_W);
    localparam int PAD_W  = NCHUNK * SCAN_W;
    localparam int PROD_W = SIZE_W + CNT_W;

    // Configuration.
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_bsize;
    logic [BCNT_W-1:0] r_bcount;

    // Pool state.
    logic [MAX_BLOCKS-1:0] r_map;
    logic [CNT_W-1:0]      r_used;

    // Working registers of one request.
    logic [ADDR_W-1:0] r_addr;
    logic [CH_W-1:0]   r_chunk;
    logic [IDX_W-1:0]  r_idx;
    logic [PROD_W-1:0] r_prod;

    // Result register.
    t_status           r_res_status;
    logic [ADDR_W-1:0] r_res_addr;
    logic              r_valid;

    logic [CNT_W-1:0]      n_act;
    logic [PAD_W-1:0]      map_pad;
    logic [SCAN_W-1:0]     chunk_bits;
    logic [SCAN_W-1:0]     free_mask;
    logic                  hit;
    logic [SEL_W-1:0]      hit_sel;
    logic [CNT_W-1:0]      mul_a;
    logic [ADDR_W:0]       end_addr;
    logic [ADDR_W-1:0]     granted;
    logic                  div_done;
    logic [ADDR_W-1:0]     quotient;
    logic [IDX_W-1:0]      free_idx;

    // Block count above the built maximum acts as the maximum.
    assign n_act = (32'(r_bcount) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(r_bcount);

    // Scan one chunk of the map per cycle; blocks past the active count
    // are masked so they are never granted.
    assign map_pad    = PAD_W'(r_map);
    assign chunk_bits = map_pad[r_chunk * SCAN_W +: SCAN_W];

    always_comb begin
        logic [CH_W+SEL_W-1:0] pos;
        hit     = 1'b0;
        hit_sel = '0;
        for (int j = 0; j < SCAN_W; j++) begin
            pos          = {r_chunk, SEL_W'(j)};
            free_mask[j] = !chunk_bits[j] && (32'(pos) < 32'(n_act));
        end
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            if (free_mask[j]) begin
                hit     = 1'b1;
                hit_sel = SEL_W'(j);
            end
        end
    end

    assign mul_a    = i_cmd.mul_cnt ? n_act : CNT_W'(r_idx);
    assign end_addr = {1'b0, r_base} + (ADDR_W + 1)'(r_prod);
    assign granted  = r_base + ADDR_W'(r_prod);
    assign free_idx = quotient[IDX_W-1:0];

    assign o_stat.scan_hit  = hit;
    assign o_stat.scan_last = (r_chunk == CH_W'(NCHUNK - 1));
    assign o_stat.addr_bad  = (r_addr == '0) || (r_addr < r_base)
                           || ({1'b0, r_addr} >= end_addr) || (r_bsize == '0);
    assign o_stat.div_done  = div_done;
    assign o_stat.slot_used = r_map[free_idx];

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_addr - r_base),
        .i_divisor  (r_bsize),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_ADDR_RST;
            r_bsize  <= BLOCK_SIZE_RST;
            r_bcount <= BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDR:   r_base   <= i_cfg_wdata[ADDR_W-1:0];
                CFG_BLOCK_SIZE:  r_bsize  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_BLOCK_COUNT: r_bcount <= i_cfg_wdata[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_used  <= '0;
            r_chunk <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_chunk <= '0;
            end else if (i_cmd.scan) begin
                r_chunk <= r_chunk + 1'b1;
            end
            if (i_cmd.clear) begin
                r_map  <= '0;
                r_used <= '0;
            end else if (i_cmd.grant) begin
                r_map[r_idx] <= 1'b1;
                r_used       <= r_used + 1'b1;
            end else if (i_cmd.release_blk) begin
                r_map[free_idx] <= 1'b0;
                r_used          <= r_used - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_req.address;
        end
        if (i_cmd.scan && hit) begin
            r_idx <= IDX_W'({r_chunk, hit_sel});
        end
        if (i_cmd.mul_idx || i_cmd.mul_cnt) begin
            r_prod <= PROD_W'(r_bsize * mul_a);
        end
        if (i_cmd.finish) begin
            r_res_status <= i_cmd.status;
            r_res_addr   <= i_cmd.grant ? granted : '0;
        end
    end

    assign o_result.status        = r_res_status;
    assign o_result.block_address = r_res_addr;
    assign o_result.used_count    = USED_W'(r_used);
    assign o_result_valid         = r_valid;

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: joins the controller and the
// datapath. Depends on fbpa_pkg, fbpa_ctrl, fbpa_dpath and fbpa_div.
`timescale 1ns / 1ps

// The allocator handles one request word at a time. A request is taken at a
// rising edge where start is high and busy is low, and busy stays high until
// the request is finished. Its result word appears on o_result for exactly one
// cycle with o_result_valid high; the receiver cannot stall it, so it must
// capture the word in that cycle. The result is shown in the first cycle in
// which busy is low again, so a new request may be issued in that same cycle.
// An allocate scans the in-use map eight blocks per cycle and then forms the
// granted address with one multiply and one add. A free computes the pool end,
// checks the bounds and then runs a one-bit-per-cycle 32-bit divide for the
// block index; an out-of-range address finishes at the bound check without a
// divide. A clear and a request of the unused type finish from their own state.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_wdata at any edge where the write enable is high, and must only be
// written while the block is idle. Writes do not touch the map or the count.

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fbpa_pkg::t_req                  i_req,
    output fbpa_pkg::t_result               o_result,
    output logic                            o_result_valid,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fbpa_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    // The controller only sequences; all state of the pool is in the datapath.
    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    fbpa_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req          (i_req),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

// ===== tb/pool_result_checker.sv =====
// Result checker for the fixed block pool allocator: mirrors the registers,
// the in-use map and the used count, predicts each result word and compares.
// Depends on fbpa_pkg only; tb_top instantiates it beside the block.
`timescale 1ns / 1ps

module pool_result_checker #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  fbpa_pkg::t_req                  i_req,
    input  fbpa_pkg::t_result               i_result,
    input  logic                            i_result_valid,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);

    import fbpa_pkg::*;

    logic [ADDR_W-1:0]     pool_base;
    logic [SIZE_W-1:0]     pool_block_size;
    logic [BCNT_W-1:0]     pool_block_count;
    logic [MAX_BLOCKS-1:0] taken_map;
    logic [USED_W-1:0]     taken_blocks;

    t_result expected_replies[$];

    // Applies one request to the mirrored pool and returns the word it answers.
    function automatic t_result predict_pool_reply(input t_req rq);
        t_result     rs;
        int unsigned span;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] addr_wide;
        logic [63:0] idx;
        logic [63:0] grant_wide;
        bit          found;
        rs.status        = ST_OK;
        rs.block_address = '0;
        span  = (pool_block_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_block_count;
        found = 1'b0;
        case (rq.req_type)
            REQ_ALLOC: begin
                for (int i = 0; i < span && !found; i++) begin
                    if (!taken_map[i]) begin
                        taken_map[i] = 1'b1;
                        taken_blocks = taken_blocks + 1'b1;
                        grant_wide = 64'(pool_base) + 64'(i) * 64'(pool_block_size);
                        rs.block_address = grant_wide[ADDR_W-1:0];
                        found = 1'b1;
                    end
                end
                if (!found) rs.status = ST_EXHAUSTED;
            end
            REQ_FREE: begin
                // The pool end is formed at 64 bits so it cannot wrap.
                lo        = 64'(pool_base);
                hi        = lo + 64'(pool_block_size) * 64'(span);
                addr_wide = 64'(rq.address);
                if (rq.address == '0 || addr_wide < lo || addr_wide >= hi ||
                    pool_block_size == '0) begin
                    rs.status = ST_INVALID;
                end else begin
                    idx = (addr_wide - lo) / 64'(pool_block_size);
                    if (idx >= 64'(MAX_BLOCKS)) begin
                        rs.status = ST_INVALID;
                    end else if (!taken_map[int'(idx)]) begin
                        rs.status = ST_NOT_ALLOC;
                    end else begin
                        taken_map[int'(idx)] = 1'b0;
                        taken_blocks = taken_blocks - 1'b1;
                    end
                end
            end
            REQ_CLEAR: begin
                taken_map    = '0;
                taken_blocks = '0;
            end
            default: ;
        endcase
        rs.used_count = taken_blocks;
        return rs;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            pool_base        = BASE_ADDR_RST;
            pool_block_size  = BLOCK_SIZE_RST;
            pool_block_count = BLOCK_COUNT_RST;
            taken_map        = '0;
            taken_blocks     = '0;
            expected_replies.delete();
        end else begin
            // The word on the result ports belongs to an earlier request, so
            // it is checked before a request taken at this same edge.
            if (i_result_valid) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result word with none expected: status %0d addr %h used %0d",
                             $time, i_result.status, i_result.block_address,
                             i_result.used_count);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_replies.pop_front();
                    o_checked = o_checked + 1;
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_result.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_result.block_address !== want.block_address) begin
                        $display("%0t: block_address expected %h, got %h",
                                 $time, want.block_address, i_result.block_address);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_result.used_count !== want.used_count) begin
                        $display("%0t: used_count expected %0d, got %0d",
                                 $time, want.used_count, i_result.used_count);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ADDR:   pool_base        = i_cfg_wdata[ADDR_W-1:0];
                    CFG_BLOCK_SIZE:  pool_block_size  = i_cfg_wdata[SIZE_W-1:0];
                    CFG_BLOCK_COUNT: pool_block_count = i_cfg_wdata[BCNT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) expected_replies.push_back(predict_pool_reply(i_req));
        end
        o_pending = expected_replies.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the allocator testbench: clock, reset, request and register stimulus,
// and the final verdict. Depends on fbpa_pkg, fixed_block_pool_allocator and
// pool_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;

    import fbpa_pkg::*;

    localparam int MAX_BLOCKS   = MAX_BLOCKS_DEF;
    // The slowest word is a free, which runs the divide, and the sender may also
    // pause between words; this limit lies well above what the whole run needs.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 1800;
    localparam int PHASE_WORDS  = 150;
    // The last stretch of the run keeps the request side busy every cycle.
    localparam int CALM_TAIL    = 100;
    // After the last result, allow a full divide of quiet time for strays.
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    t_result               o_result;
    logic                  o_result_valid;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_BASE_ADDR;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_total;
    int pending_words;
    int checked_words;
    int cycle_count = 0;

    // Copies of the registers as last written, used only to aim free
    // requests inside the pool and at its boundaries.
    logic [ADDR_W-1:0] cur_base  = BASE_ADDR_RST;
    logic [SIZE_W-1:0] cur_size  = BLOCK_SIZE_RST;
    logic [BCNT_W-1:0] cur_count = BLOCK_COUNT_RST;

    int n_alloc    = 0;
    int n_free     = 0;
    int n_clear    = 0;
    int n_other    = 0;
    int n_settings = 0;

    fixed_block_pool_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    pool_result_checker #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_result       (o_result),
        .i_result_valid (o_result_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_total),
        .o_pending      (pending_words),
        .o_checked      (checked_words)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // A hung handshake or a result that never comes ends the run here.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d result words outstanding",
                     cycle_count, pending_words);
            $display("Test completed with failures");
            $finish;
        end
    end

    // All driving happens at the falling edge, and the DUT samples at the
    // rising edge. A word is presented with start high and held until an edge
    // sees busy low. The task returns at the falling edge after acceptance
    // with start still high, so the caller can either present the next word
    // right away or drop start; either way start is assigned once per step.
    task automatic issue_word(input t_req_type kind, input logic [ADDR_W-1:0] addr);
        logic taken;
        start          = 1'b1;
        i_req.req_type = kind;
        i_req.address  = addr;
        case (kind)
            REQ_ALLOC: n_alloc++;
            REQ_FREE:  n_free++;
            REQ_CLEAR: n_clear++;
            default:   n_other++;
        endcase
        do begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic pause_sender(input int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stops issuing and waits for every predicted result word to arrive, so
    // the block is idle before registers change.
    task automatic drain_pool();
        start = 1'b0;
        while (pending_words != 0) @(negedge i_clk);
    endtask

    // Writes all three registers on consecutive edges once the block is idle.
    task automatic apply_setting(input logic [ADDR_W-1:0] base,
                                 input logic [SIZE_W-1:0] size,
                                 input logic [BCNT_W-1:0] count);
        drain_pool();
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_BASE_ADDR;
        i_cfg_wdata = CFG_DATA_W'(base);
        @(negedge i_clk);
        i_cfg_index = CFG_BLOCK_SIZE;
        i_cfg_wdata = CFG_DATA_W'(size);
        @(negedge i_clk);
        i_cfg_index = CFG_BLOCK_COUNT;
        i_cfg_wdata = CFG_DATA_W'(count);
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        cur_base  = base;
        cur_size  = size;
        cur_count = count;
        n_settings++;
    endtask

    // One random request word. Most are allocates and frees aimed inside the
    // pool, so the map fills and drains and the not-allocated, exhausted and
    // successful paths all get exercised; the rest are stray addresses, the
    // pool boundaries, clears and the unused request type.
    task automatic random_word(output bit counted);
        int unsigned       pick;
        int unsigned       span;
        logic [63:0]       wide;
        logic [ADDR_W-1:0] addr;
        pick    = $urandom_range(0, 99);
        span    = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
        counted = 1'b1;
        if (pick < 45) begin
            issue_word(REQ_ALLOC, $urandom());
        end else if (pick < 80) begin
            wide = 64'(cur_base)
                 + 64'($urandom_range(0, (span == 0) ? 0 : span - 1)) * 64'(cur_size)
                 + 64'($urandom_range(0, (cur_size == 0) ? 0 : cur_size - 1));
            issue_word(REQ_FREE, wide[ADDR_W-1:0]);
        end else if (pick < 88) begin
            issue_word(REQ_FREE, $urandom());
        end else if (pick < 93) begin
            wide = 64'(cur_base) + 64'(cur_size) * 64'(span);
            case ($urandom_range(0, 3))
                0:       addr = '0;
                1:       addr = cur_base - 1'b1;
                2:       addr = wide[ADDR_W-1:0];
                default: addr = wide[ADDR_W-1:0] - 1'b1;
            endcase
            issue_word(REQ_FREE, addr);
        end else if (pick < 97) begin
            issue_word(REQ_CLEAR, $urandom());
        end else begin
            // The unused type changes nothing, so it is not counted as work.
            issue_word(REQ_NONE, $urandom());
            counted = 1'b0;
        end
    endtask

    initial begin : stimulus
        int random_sent;
        int phase;
        int gap_odds;
        bit counted;

        random_sent = 0;
        phase       = 0;

        // Reset is held from the start of the run and released once.
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset settings: free of zero, free of an unused
        // block, two grants, an unaligned free inside a block, addresses just
        // below the base, at the pool end and at the top of the address range,
        // the unused request type, and reuse of the lowest free block.
        issue_word(REQ_FREE,  '0);
        issue_word(REQ_FREE,  32'd4096);
        issue_word(REQ_ALLOC, '1);
        issue_word(REQ_ALLOC, '0);
        issue_word(REQ_FREE,  32'd4096 + 32'd64 + 32'd37);
        issue_word(REQ_FREE,  32'd4095);
        issue_word(REQ_FREE,  32'd8192);
        issue_word(REQ_FREE,  32'd8191);
        issue_word(REQ_FREE,  32'hFFFF_FFFF);
        issue_word(REQ_NONE,  32'hFFFF_FFFF);
        issue_word(REQ_ALLOC, '0);

        // A pool shrunk to two blocks that are both taken is full.
        apply_setting(32'd4096, 16'd64, 7'd2);
        issue_word(REQ_ALLOC, '0);

        // A zero block count: nothing to grant and no valid address.
        apply_setting(32'd4096, 16'd64, 7'd0);
        issue_word(REQ_ALLOC, '0);
        issue_word(REQ_FREE,  32'd4096);

        // A zero block size: the pool span is empty, yet a grant still lands
        // at the base address.
        apply_setting(32'd4096, 16'd0, 7'd64);
        issue_word(REQ_FREE,  32'd4096);
        issue_word(REQ_ALLOC, '0);

        // A count beyond the built maximum, a base near the top of the address
        // space and the largest block size: grants wrap to 32 bits while the
        // pool end does not, so the top address frees block zero.
        apply_setting(32'hFFFF_FF00, 16'hFFFF, 7'd100);
        issue_word(REQ_ALLOC, '0);
        issue_word(REQ_FREE,  32'hFFFF_FFFF);
        issue_word(REQ_ALLOC, '0);
        issue_word(REQ_CLEAR, '0);
        issue_word(REQ_ALLOC, '0);

        // Random part, in phases with a fresh register setting each. Some
        // phases have no sender gaps at all; the others vary in how often the
        // sender goes quiet. The setting change itself makes the sender wait
        // for every outstanding result word.
        while (random_sent < RANDOM_WORDS) begin
            case (phase % 6)
                0: apply_setting($urandom_range(1, 32'hFFFF_FFFF),
                                 SIZE_W'($urandom_range(1, 256)),
                                 BCNT_W'($urandom_range(1, 64)));
                1: apply_setting(32'd1, 16'd1, BCNT_W'($urandom_range(1, 8)));
                2: apply_setting(32'hFFFF_FFFF - $urandom_range(0, 255),
                                 16'hFFFF, 7'd64);
                3: apply_setting($urandom_range(1, 32'hFFFF_FFFF),
                                 SIZE_W'($urandom_range(1, 65535)),
                                 BCNT_W'($urandom_range(65, 127)));
                4: apply_setting(BASE_ADDR_RST, BLOCK_SIZE_RST, BLOCK_COUNT_RST);
                default: apply_setting($urandom_range(1, 32'hFFFF_FFFF),
                                       SIZE_W'($urandom_range(1, 16)),
                                       BCNT_W'($urandom_range(1, 127)));
            endcase
            gap_odds = $urandom_range(0, 3);
            for (int k = 0; k < PHASE_WORDS && random_sent < RANDOM_WORDS; ) begin
                random_word(counted);
                if (counted) begin
                    k++;
                    random_sent++;
                end
                if (random_sent < RANDOM_WORDS - CALM_TAIL && gap_odds != 0 &&
                    $urandom_range(1, 8) <= gap_odds)
                    pause_sender($urandom_range(1, 5));
            end
            phase++;
        end

        // Let everything settle, then give the verdict.
        drain_pool();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests (%0d allocate, %0d free, %0d clear, %0d unused type)",
                 n_alloc + n_free + n_clear + n_other, n_alloc, n_free, n_clear, n_other);
        $display("under %0d register settings; %0d result words checked, %0d mismatches.",
                 n_settings, checked_words, fail_total);
        if (fail_total == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
